>>> rtl/afsp_pkg.sv
// Package for the adaptive frame-skip pacer.
// Holds the shared types, register indexes, command codes and timing constants.
// No dependencies.
`default_nettype none

package afsp_pkg;

    localparam int TICK_RATE       = 128;
    localparam int SECONDS_PER_DAY = 86400;
    localparam int DAY_TICKS_INT   = TICK_RATE * SECONDS_PER_DAY;
    localparam logic [31:0] DAY_TICKS = 32'(DAY_TICKS_INT);

    // Width of an elapsed-tick count below one day, and of the wanted product.
    localparam int ELAPSED_W = $clog2(DAY_TICKS_INT);
    localparam int WANTED_W  = 8 + ELAPSED_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RATE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

    localparam logic [7:0] RESET_TARGET_RATE   = 8'd60;
    localparam logic [5:0] RESET_SKIP_LIMIT    = 6'd9;
    localparam logic [6:0] RESET_WINDOW_LENGTH = 7'd30;

    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [7:0] target_rate;
        logic [5:0] skip_limit;
        logic [6:0] window_length;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ticks;
    } item_t;

    typedef struct packed {
        logic       render;
        logic [5:0] skip_level;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/afsp_cfg_regs.sv
// Configuration registers of the frame-skip pacer.
// Depends on afsp_pkg for register indexes and reset values.
`default_nettype none

module afsp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [afsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [afsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output afsp_pkg::cfg_t                       cfg
);
    import afsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_RATE:   cfg_next.target_rate   = cfg_data[7:0];
                REG_SKIP_LIMIT:    cfg_next.skip_limit    = cfg_data[5:0];
                REG_WINDOW_LENGTH: cfg_next.window_length = cfg_data[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_rate   <= RESET_TARGET_RATE;
            cfg_reg.skip_limit    <= RESET_SKIP_LIMIT;
            cfg_reg.window_length <= RESET_WINDOW_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/afsp_in_reg.sv
// Input register of the frame-skip pacer: holds one accepted item.
// Depends on afsp_pkg for the item type.
`default_nettype none

module afsp_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire afsp_pkg::item_t in_item,
    output logic                 item_valid,
    output afsp_pkg::item_t      item,
    input  wire logic            item_take
);
    import afsp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_ready   = !valid_reg || item_take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/afsp_core.sv
// Pacing state and single-pass update of the frame-skip pacer.
// Depends on afsp_pkg for types, command codes and tick constants.
`default_nettype none

module afsp_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire afsp_pkg::cfg_t  cfg,
    input  wire logic            item_valid,
    input  wire afsp_pkg::item_t item,
    output logic                 item_take,
    input  wire logic            out_free,
    output logic                 res_valid,
    output afsp_pkg::result_t    res
);
    import afsp_pkg::*;

    logic [5:0]  skip_now_reg,          skip_now_next;
    logic [5:0]  frames_since_draw_reg, frames_since_draw_next;
    logic [6:0]  window_count_reg,      window_count_next;
    logic [31:0] window_start_reg,      window_start_next;

    logic [7:0]           count_inc;
    logic                 close;
    logic [31:0]          diff;
    logic [ELAPSED_W-1:0] elapsed;
    logic [WANTED_W-1:0]  achieved;
    logic [WANTED_W-1:0]  wanted;
    logic [6:0]           skip_step;
    logic [5:0]           skip_sat;
    logic [5:0]           skip_new;
    logic                 render;
    logic                 is_restart;

    assign is_restart = (item.cmd == CMD_RESTART);
    // A restart needs no output slot, so it never waits on the receiver.
    assign item_take  = item_valid && (is_restart || out_free);
    assign res_valid  = item_take && !is_restart;

    assign count_inc = {1'b0, window_count_reg} + 8'd1;
    assign close     = count_inc >= {1'b0, cfg.window_length};
    assign diff      = item.now_ticks - window_start_reg;
    // A gap of a day or more is treated as no time elapsed.
    assign elapsed   = (diff < DAY_TICKS) ? diff[ELAPSED_W-1:0] : '0;
    assign achieved  = WANTED_W'(count_inc[6:0]) * WANTED_W'(TICK_RATE);
    assign wanted    = WANTED_W'(cfg.target_rate) * WANTED_W'(elapsed);

    always_comb
    begin
        if (achieved < wanted)
        begin
            skip_step = {1'b0, skip_now_reg} + 7'd1;
        end
        else if (skip_now_reg == 6'd0)
        begin
            skip_step = 7'd0;
        end
        else
        begin
            skip_step = {1'b0, skip_now_reg} - 7'd1;
        end
        if (skip_step > {1'b0, cfg.skip_limit})
        begin
            skip_sat = cfg.skip_limit;
        end
        else
        begin
            skip_sat = skip_step[5:0];
        end
    end

    assign skip_new = (close && (elapsed != '0)) ? skip_sat : skip_now_reg;
    assign render   = frames_since_draw_reg >= skip_new;

    assign res.render     = render;
    assign res.skip_level = skip_new;

    always_comb
    begin
        skip_now_next          = skip_now_reg;
        frames_since_draw_next = frames_since_draw_reg;
        window_count_next      = window_count_reg;
        window_start_next      = window_start_reg;
        if (item_take)
        begin
            if (is_restart)
            begin
                skip_now_next          = 6'd0;
                frames_since_draw_next = 6'd0;
                window_count_next      = 7'd0;
                window_start_next      = item.now_ticks;
            end
            else
            begin
                skip_now_next          = skip_new;
                frames_since_draw_next = render ? 6'd0 : frames_since_draw_reg + 6'd1;
                window_count_next      = close ? 7'd0 : count_inc[6:0];
                window_start_next      = close ? item.now_ticks : window_start_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_now_reg          <= 6'd0;
            frames_since_draw_reg <= 6'd0;
            window_count_reg      <= 7'd0;
            window_start_reg      <= 32'd0;
        end
        else
        begin
            skip_now_reg          <= skip_now_next;
            frames_since_draw_reg <= frames_since_draw_next;
            window_count_reg      <= window_count_next;
            window_start_reg      <= window_start_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/afsp_out_reg.sv
// Result register of the frame-skip pacer, decoupling the core from the receiver.
// Depends on afsp_pkg for the result type.
`default_nettype none

module afsp_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire afsp_pkg::result_t res,
    output logic                   out_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output afsp_pkg::result_t      out_res
);
    import afsp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/adaptive_frame_skip_pacer_top.sv
// Adaptive frame-skip pacer, top level.
// Depends on afsp_pkg, afsp_cfg_regs, afsp_in_reg, afsp_core and afsp_out_reg.
//
// Usage:
//   The input stream carries one transaction per frame event or restart:
//   s_tuser is the command (frame or restart), s_tdata the current tick count.
//   Each frame event yields one output transaction telling whether to draw the
//   frame and the skip level after its update; a restart clears the pacing
//   state, latches the tick count and yields nothing.
//   The configuration channel writes target_rate (index 0), skip_limit (1)
//   and window_length (2); it is always ready. Write only while idle.
// Timing:
//   An accepted item is held in the input register; the skip update, with its
//   8 x 24 bit multiply and compare, is combinational on that register, and the
//   result is loaded into the output register when the item is taken. One item
//   is accepted every cycle while the output register is free to take it.
// Reset and stalls:
//   Reset clears the pacing state and loads the default register values.
//   While m_tready is low with a result held, one more frame waits in the
//   input register and then s_tready drops; until then restarts still pass.
`default_nettype none

module adaptive_frame_skip_pacer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,   // [31:0] now_ticks
    input  wire logic [0:0]                       s_tuser,   // [0] cmd
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,   // [0] render, [6:1] skip_level
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [afsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [afsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import afsp_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    logic    out_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.cmd       = s_tuser[0];
    assign in_item.now_ticks = s_tdata;
    assign m_tdata           = {1'b0, out_res.skip_level, out_res.render};

    afsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afsp_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    afsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    afsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

endmodule

`default_nettype wire
